FILE: hw/rtl/u2u_pkg.sv
// shared types and constants of the utf-8 to utf-16 decoder
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] Replacement  = 16'hFFFD;
  localparam logic [20:0] MaxPoint     = 21'h10FFFF;
  localparam logic [20:0] SurrFirst    = 21'h00D800;
  localparam logic [20:0] SurrLast     = 21'h00DFFF;
  localparam logic [20:0] SupplBase    = 21'h010000;
  localparam logic [20:0] MinTwoByte   = 21'h000080;
  localparam logic [20:0] MinThreeByte = 21'h000800;
  localparam logic [20:0] MinFourByte  = 21'h010000;
  localparam logic [5:0]  HiSurrPrefix = 6'b110110;
  localparam logic [5:0]  LoSurrPrefix = 6'b110111;

  // length of the sequence announced by the lead byte of the open run
  typedef enum logic [1:0] {
    RunNone  = 2'd0,
    RunTwo   = 2'd1,
    RunThree = 2'd2,
    RunFour  = 2'd3
  } run_e;

  // one queued command: one or two code units caused by one input item
  typedef struct packed {
    logic        two;
    logic        str_end;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/utf8_to_utf16_decoder.sv
// utf-8 to utf-16 decoder top level
// an accepted item's command is registered in the queue; its units leave from the head
// throughput: one byte per cycle while the queue is not full; an item that yields a
//   surrogate pair or a replacement plus a unit sends two units, the queue absorbs it
// reset clears the open run and empties the queue; no units are pending after reset
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder #(
  parameter int unsigned QueueDepth = u2u_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tlast,   // string_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // code_unit
  output logic [0:0]       m_axis_tuser,   // item_last
  output logic             m_axis_tlast    // string_done
);

  logic          full, empty, push, pop, accept;
  u2u_pkg::cmd_t push_cmd, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  u2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (s_axis_tdata),
    .string_end_i (s_axis_tlast),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  u2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  u2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .code_unit_o   (m_axis_tdata),
    .item_last_o   (m_axis_tuser[0]),
    .string_done_o (m_axis_tlast)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("end of string on a unit that is not the last of its item");

endmodule

`default_nettype wire

FILE: hw/rtl/u2u_front.sv
// front end: accepts bytes, tracks the open run and builds unit commands
`timescale 1ns / 1ps
`default_nettype none

module u2u_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          string_end_i,
  output logic               push_o,
  output u2u_pkg::cmd_t      push_cmd_o
);

  logic [20:0]       pp_q, pp_d;
  logic [1:0]        pend_q, pend_d;
  u2u_pkg::run_e     run_q, run_d;

  logic [20:0] acc;
  logic [20:0] suppl;
  logic [1:0]  pend_m1;
  logic        cont;
  logic        point_ok;
  logic        fresh;
  logic        lead;
  logic [1:0]  n;
  logic [15:0] u0, u1;

  assign cont    = (in_byte_i[7:6] == 2'b10);
  assign acc     = {pp_q[14:0], in_byte_i[5:0]};
  assign pend_m1 = pend_q - 2'd1;
  assign suppl   = acc - u2u_pkg::SupplBase;

  always_comb begin
    point_ok = 1'b1;
    if (acc > u2u_pkg::MaxPoint) point_ok = 1'b0;
    if (acc inside {[u2u_pkg::SurrFirst : u2u_pkg::SurrLast]}) point_ok = 1'b0;
    case (run_q)
      u2u_pkg::RunTwo:   if (acc < u2u_pkg::MinTwoByte) point_ok = 1'b0;
      u2u_pkg::RunThree: if (acc < u2u_pkg::MinThreeByte) point_ok = 1'b0;
      u2u_pkg::RunFour:  if (acc < u2u_pkg::MinFourByte) point_ok = 1'b0;
      default:           point_ok = point_ok;
    endcase
  end

  always_comb begin
    pp_d   = pp_q;
    pend_d = pend_q;
    run_d  = run_q;
    n      = 2'd0;
    u0     = '0;
    u1     = '0;
    fresh  = 1'b1;
    lead   = 1'b0;

    if (pend_q != 2'd0) begin
      if (cont) begin
        fresh  = 1'b0;
        pp_d   = acc;
        pend_d = pend_m1;
        if (pend_m1 == 2'd0) begin
          pp_d  = '0;
          run_d = u2u_pkg::RunNone;
          if (!point_ok) begin
            u0 = u2u_pkg::Replacement;
            n  = 2'd1;
          end else if (acc[20:16] != 5'd0) begin
            // surrogate pair
            u0 = {u2u_pkg::HiSurrPrefix, suppl[19:10]};
            u1 = {u2u_pkg::LoSurrPrefix, suppl[9:0]};
            n  = 2'd2;
          end else begin
            u0 = acc[15:0];
            n  = 2'd1;
          end
        end else if (string_end_i) begin
          u0     = u2u_pkg::Replacement;
          n      = 2'd1;
          pp_d   = '0;
          pend_d = 2'd0;
          run_d  = u2u_pkg::RunNone;
        end
      end else begin
        // cut-short run, the byte is decoded afresh below
        u0     = u2u_pkg::Replacement;
        n      = 2'd1;
        pp_d   = '0;
        pend_d = 2'd0;
        run_d  = u2u_pkg::RunNone;
      end
    end

    if (fresh) begin
      if (!in_byte_i[7]) begin
        if (n == 2'd0) u0 = {8'd0, in_byte_i};
        else           u1 = {8'd0, in_byte_i};
        n = n + 2'd1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        lead   = 1'b1;
        pp_d   = {16'd0, in_byte_i[4:0]};
        pend_d = 2'd1;
        run_d  = u2u_pkg::RunTwo;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        lead   = 1'b1;
        pp_d   = {17'd0, in_byte_i[3:0]};
        pend_d = 2'd2;
        run_d  = u2u_pkg::RunThree;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        lead   = 1'b1;
        pp_d   = {18'd0, in_byte_i[2:0]};
        pend_d = 2'd3;
        run_d  = u2u_pkg::RunFour;
      end else begin
        if (n == 2'd0) u0 = u2u_pkg::Replacement;
        else           u1 = u2u_pkg::Replacement;
        n = n + 2'd1;
      end
      if (lead && string_end_i) begin
        // run truncated by the end of the string
        if (n == 2'd0) u0 = u2u_pkg::Replacement;
        else           u1 = u2u_pkg::Replacement;
        n      = n + 2'd1;
        pp_d   = '0;
        pend_d = 2'd0;
        run_d  = u2u_pkg::RunNone;
      end
    end
  end

  assign push_o             = accept_i && (n != 2'd0);
  assign push_cmd_o.two     = (n == 2'd2);
  assign push_cmd_o.str_end = string_end_i;
  assign push_cmd_o.unit0   = u0;
  assign push_cmd_o.unit1   = u1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      pend_q <= 2'd0;
      run_q  <= u2u_pkg::RunNone;
    end else if (accept_i) begin
      pp_q   <= pp_d;
      pend_q <= pend_d;
      run_q  <= run_d;
    end
  end

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && string_end_i |=> pend_q == 2'd0)
    else $error("run still open after end of string");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> run_q == u2u_pkg::RunNone && pp_q == 21'd0)
    else $error("idle state holds stale run data");

endmodule

`default_nettype wire

FILE: hw/rtl/u2u_queue.sv
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module u2u_queue #(
  parameter int unsigned Depth = u2u_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  u2u_pkg::cmd_t      push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output u2u_pkg::cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::cmd_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/u2u_back.sv
// back end: sends the one or two code units of each queued command
`timescale 1ns / 1ps
`default_nettype none

module u2u_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  u2u_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [15:0]        code_unit_o,
  output logic               item_last_o,
  output logic               string_done_o
);

  logic sel_q, sel_d;
  logic last;
  logic fire;

  assign out_valid_o   = !empty_i;
  assign last          = !head_i.two || sel_q;
  assign fire          = out_valid_o && out_ready_i;
  assign code_unit_o   = sel_q ? head_i.unit1 : head_i.unit0;
  assign item_last_o   = last;
  assign string_done_o = last && head_i.str_end;
  assign pop_o         = fire && last;

  always_comb begin
    sel_d = sel_q;
    if (fire) sel_d = !last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  a_sel_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> !empty_i && head_i.two)
    else $error("second unit selected without a pair");

endmodule

`default_nettype wire
